// ===== rtl/core/ifrp_pkg.sv =====
// ----------------------------------------------------------------------------
// ifrp_pkg: shared types and constants of the index file record parser
// Parse stages, result kinds, error codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package ifrp_pkg;

	// Parse stages, one-hot.
	typedef enum logic [10:0] {
		ST_SIG   = 11'b000_0000_0001,
		ST_VER   = 11'b000_0000_0010,
		ST_CNT   = 11'b000_0000_0100,
		ST_META  = 11'b000_0000_1000,
		ST_HASH  = 11'b000_0001_0000,
		ST_FLAGS = 11'b000_0010_0000,
		ST_PATH  = 11'b000_0100_0000,
		ST_PAD   = 11'b000_1000_0000,
		ST_SUM   = 11'b001_0000_0000,
		ST_DONE  = 11'b010_0000_0000,
		ST_HALT  = 11'b100_0000_0000
	} stage_t;

	// Result kinds.
	localparam logic [4:0] KIND_SIG   = 5'd0;
	localparam logic [4:0] KIND_VER   = 5'd1;
	localparam logic [4:0] KIND_CNT   = 5'd2;
	localparam logic [4:0] KIND_META0 = 5'd3;
	localparam logic [4:0] KIND_HASH  = 5'd13;
	localparam logic [4:0] KIND_FLAGS = 5'd14;
	localparam logic [4:0] KIND_PATH  = 5'd15;
	localparam logic [4:0] KIND_SUM   = 5'd16;
	localparam logic [4:0] KIND_ERR   = 5'd17;

	// Error codes carried in the value field.
	localparam logic [31:0] ERR_TRUNCATED = 32'd0;
	localparam logic [31:0] ERR_EXCESS    = 32'd1;

	// Field group lengths in bytes.
	localparam logic [11:0] HDR_BYTES  = 12'd4;
	localparam logic [11:0] META_BYTES = 12'd40;
	localparam logic [11:0] HASH_BYTES = 12'd20;
	localparam logic [11:0] HASH_LAST  = 12'd19;
	localparam logic [11:0] FLAG_BYTES = 12'd2;

	// One result of the parser.
	typedef struct packed {
		logic        valid;
		logic [4:0]  kind;
		logic [31:0] value;
		logic [31:0] entry;
		logic [11:0] word;
		logic        done;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/core/ifrp_parser.sv =====
// ----------------------------------------------------------------------------
// ifrp_parser: parse state and per-byte next-state logic
// Holds the parse state and turns one byte into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module ifrp_parser
	import ifrp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       first_byte,
	input  wire logic       final_byte,
	input  wire logic       align_mode,
	output res_t            res
);

	stage_t      stage_q, st, st_n, fin_stage;
	logic [11:0] bif_q, bif, bif_n, bif_inc;
	logic [31:0] acc_q, acc, acc_n, acc_sh;
	logic [31:0] tot_q, tot, tot_n;
	logic [31:0] cnt_q, cnt, cnt_n, cnt_inc;
	logic [11:0] len_q, len, len_n;
	logic [12:0] off_q, off, off_n, off_inc;
	logic [3:0]  pad_q, pad, pad_n, pad_dec, pad_align, pad_path;

	// A first byte restarts the parse before the byte is taken.
	always_comb begin
		st  = first_byte ? ST_SIG : stage_q;
		bif = first_byte ? 12'd0 : bif_q;
		acc = first_byte ? 32'd0 : acc_q;
		tot = first_byte ? 32'd0 : tot_q;
		cnt = first_byte ? 32'd0 : cnt_q;
		len = first_byte ? 12'd0 : len_q;
		off = first_byte ? 13'd0 : off_q;
		pad = first_byte ? 4'd0 : pad_q;
	end

	assign bif_inc   = bif + 12'd1;
	assign cnt_inc   = cnt + 32'd1;
	assign off_inc   = off + 13'd1;
	assign acc_sh    = {acc[23:0], data_byte};
	assign pad_dec   = (pad != 4'd0) ? pad - 4'd1 : pad;
	assign pad_align = 4'd8 - {1'b0, off_inc[2:0]};
	assign pad_path  = align_mode ? pad_align : {3'b000, len[0]};
	assign fin_stage = (cnt_inc == tot) ? ST_SUM : ST_META;

	always_comb begin
		st_n  = st;
		bif_n = bif;
		acc_n = acc;
		tot_n = tot;
		cnt_n = cnt;
		len_n = len;
		off_n = off;
		pad_n = pad;
		res       = '0;
		res.entry = cnt;
		case (st)
			ST_HALT: begin
			end
			ST_DONE: begin
				res.valid = 1'b1;
				res.kind  = KIND_ERR;
				res.value = ERR_EXCESS;
				st_n      = ST_HALT;
			end
			ST_SIG, ST_VER, ST_CNT: begin
				acc_n = acc_sh;
				bif_n = bif_inc;
				if (bif_inc == HDR_BYTES) begin
					res.valid = 1'b1;
					res.kind  = (st == ST_SIG) ? KIND_SIG :
					            (st == ST_VER) ? KIND_VER : KIND_CNT;
					res.value = acc_sh;
					bif_n     = 12'd0;
					if (st == ST_CNT) begin
						tot_n = acc_sh;
						cnt_n = 32'd0;
						off_n = 13'd0;
						st_n  = (acc_sh != 32'd0) ? ST_META : ST_SUM;
					end else begin
						st_n = (st == ST_SIG) ? ST_VER : ST_CNT;
					end
				end
			end
			ST_META: begin
				acc_n = acc_sh;
				off_n = off_inc;
				bif_n = bif_inc;
				if (bif_inc[1:0] == 2'b00) begin
					res.valid = 1'b1;
					res.kind  = KIND_META0 + 5'(bif[11:2]);
					res.value = acc_sh;
				end
				if (bif_inc == META_BYTES) begin
					bif_n = 12'd0;
					st_n  = ST_HASH;
				end
			end
			ST_HASH: begin
				acc_n = acc_sh;
				off_n = off_inc;
				bif_n = bif_inc;
				if (bif_inc[1:0] == 2'b00) begin
					res.valid = 1'b1;
					res.kind  = KIND_HASH;
					res.value = acc_sh;
					res.word  = {2'b00, bif[11:2]};
				end
				if (bif_inc == HASH_BYTES) begin
					bif_n = 12'd0;
					st_n  = ST_FLAGS;
				end
			end
			ST_FLAGS: begin
				acc_n = acc_sh;
				off_n = off_inc;
				bif_n = bif_inc;
				if (bif_inc == FLAG_BYTES) begin
					bif_n     = 12'd0;
					len_n     = acc_sh[11:0];
					res.valid = 1'b1;
					res.kind  = KIND_FLAGS;
					res.value = {16'd0, acc_sh[15:0]};
					if (acc_sh[11:0] != 12'd0) begin
						st_n = ST_PATH;
					end else begin
						// Empty name: the flags close the entry.
						res.done = 1'b1;
						if (align_mode) begin
							pad_n = pad_align;
							st_n  = ST_PAD;
						end else begin
							cnt_n = cnt_inc;
							off_n = 13'd0;
							st_n  = fin_stage;
						end
					end
				end
			end
			ST_PATH: begin
				acc_n     = acc_sh;
				off_n     = off_inc;
				bif_n     = bif_inc;
				res.valid = 1'b1;
				res.kind  = KIND_PATH;
				res.value = {24'd0, data_byte};
				res.word  = bif;
				if (bif_inc == len) begin
					res.done = 1'b1;
					bif_n    = 12'd0;
					if (pad_path == 4'd0) begin
						cnt_n = cnt_inc;
						off_n = 13'd0;
						st_n  = fin_stage;
					end else begin
						pad_n = pad_path;
						st_n  = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				acc_n = acc_sh;
				off_n = off_inc;
				pad_n = pad_dec;
				if (pad_dec == 4'd0) begin
					cnt_n = cnt_inc;
					off_n = 13'd0;
					bif_n = 12'd0;
					st_n  = fin_stage;
				end
			end
			ST_SUM: begin
				acc_n = acc_sh;
				bif_n = bif_inc;
				if (bif_inc[1:0] == 2'b00) begin
					res.valid = 1'b1;
					res.kind  = KIND_SUM;
					res.value = acc_sh;
					res.word  = {2'b00, bif[11:2]};
				end
				if (bif_inc > HASH_LAST) begin
					bif_n = 12'd0;
					st_n  = ST_DONE;
				end
			end
			default: begin
				st_n = ST_HALT;
			end
		endcase
		// A file that ends before the trailer is complete replaces any field result.
		if (final_byte && st != ST_HALT && st != ST_DONE && st_n != ST_DONE) begin
			res.valid = 1'b1;
			res.kind  = KIND_ERR;
			res.value = ERR_TRUNCATED;
			res.word  = 12'd0;
			res.done  = 1'b0;
			res.entry = cnt_n;
			st_n      = ST_HALT;
		end
		if (!step) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_SIG;
			bif_q   <= '0;
			acc_q   <= '0;
			tot_q   <= '0;
			cnt_q   <= '0;
			len_q   <= '0;
			off_q   <= '0;
			pad_q   <= '0;
		end else if (step) begin
			stage_q <= st_n;
			bif_q   <= bif_n;
			acc_q   <= acc_n;
			tot_q   <= tot_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
			off_q   <= off_n;
			pad_q   <= pad_n;
		end
	end

	a_pad_live: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == ST_PAD |-> (pad_q != 4'd0 && pad_q <= 4'd8))
		else $error("pad stage with no pad bytes left");
	a_meta_range: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == ST_META |-> bif_q < META_BYTES)
		else $error("metadata byte count out of range");
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == ST_SUM |-> bif_q < HASH_BYTES)
		else $error("checksum byte count out of range");
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(step && stage_q == ST_HALT && !first_byte) |-> !res.valid)
		else $error("result produced while halted");

endmodule

`default_nettype wire

// ===== rtl/core/ifrp_out_stage.sv =====
// ----------------------------------------------------------------------------
// ifrp_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ifrp_out_stage
	import ifrp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire res_t res,
	input  wire logic out_ready,
	output logic      out_valid,
	output logic      can_load,
	output res_t      res_s2
);

	logic valid_s2;

	assign can_load  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |-> !load)
		else $error("result register overwritten before it was taken");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_s2)
		else $error("loaded result not presented");
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_ready && !load) |=> !valid_s2)
		else $error("taken result still presented");

endmodule

`default_nettype wire

// ===== rtl/core/index_file_record_parser.sv =====
// ----------------------------------------------------------------------------
// index_file_record_parser: streaming parser of a directory-cache index file
// Takes the file one byte per request and reports header fields, entry
// fields, path bytes, trailer checksum words and format errors.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  -------   ---------  ------------------------------------------------------
//  s_axis    in         tdata: data_byte; tuser: first_byte; tlast: final_byte
//  m_axis    out        tdata: value, entry number, word number; tuser: kind;
//                       tlast: entry_done
//  cfg       in         cfg_wdata: align_mode, written when cfg_we is high
//
// One byte request is accepted per clock cycle unless a stall on m_axis
// holds the input register. A byte sits in the input register while the
// parser updates its state and forms at most one result, which is
// registered into the result register. The per-byte stage update and the
// 32-bit shift-accumulate set the cycle time. Pad bytes and the inner bytes
// of a multi-byte field give no result.
// Reset clears the parse state to the signature stage and empties both
// registers; no clearing pass is needed.
// A stall on m_axis holds the input register only once it carries a byte
// whose turn has come while the result register is still full; the ready
// on s_axis follows m_axis_tready combinationally in that case.
// ----------------------------------------------------------------------------
`default_nettype none

module index_file_record_parser
	import ifrp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: align_mode.
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	// Byte stream in.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_axis_tuser,   // [0] first_byte
	input  wire logic        s_axis_tlast,   // final_byte
	// Result stream out.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,   // [31:0] field_value, [63:32] entry_number,
	                                         // [75:64] word_number, [79:76] zero
	output logic [4:0]       m_axis_tuser,   // [4:0] field_kind
	output logic             m_axis_tlast    // entry_done
);

	logic       align_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       final_s1;
	logic       advance;
	logic       can_load;
	res_t       res;
	res_t       res_s2;

	// The alignment mode is to be changed by the user only while the parser is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= 1'b0;
		end else if (cfg_we) begin
			align_q <= cfg_wdata;
		end
	end

	// The byte in the input register is parsed in the cycle that the
	// result register can take whatever it produces.
	assign advance       = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser[0];
			final_s1 <= s_axis_tlast;
		end
	end

	ifrp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.first_byte (first_s1),
		.final_byte (final_s1),
		.align_mode (align_q),
		.res        (res)
	);

	ifrp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res.valid),
		.res       (res),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.can_load  (can_load),
		.res_s2    (res_s2)
	);

	assign m_axis_tdata = {4'd0, res_s2.word, res_s2.entry, res_s2.value};
	assign m_axis_tuser = res_s2.kind;
	assign m_axis_tlast = res_s2.done;

	a_res_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> advance)
		else $error("parser result without an advancing byte");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !can_load) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a byte during a stall");
	a_kind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= KIND_ERR)
		else $error("result kind out of range");

endmodule

`default_nettype wire
